@@ design/ght_pkg.sv @@
package ght_pkg;

   typedef enum logic [1:0] {
      FUNC_INTERN  = 2'd0,
      FUNC_LOOKUP  = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] object_id;
      logic [3:0]  object_kind;
      logic [63:0] handle_in;
   } req_type;

   typedef struct packed {
      logic [63:0] handle_out;
      logic        ok;
      logic [3:0]  kind_out;
      logic [63:0] object_out;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;      // capture request, reset scan pointer
      logic rd_slot;       // read slot at scan pointer (or handle index or popped stack entry)
      logic use_handle;    // address from handle instead of scan pointer
      logic use_stack;     // address from popped stack entry
      logic scan_next;     // advance scan pointer
      logic intern_alloc;  // allocate slot and write it
      logic do_release;    // free addressed slot, push to stack
      logic clear_slot;    // free slot at scan pointer, push as stack entry
      logic clear_start;   // reset free count
      logic rd_stack;      // read top of free stack
      logic set_hit;       // result from found slot
      logic set_lookup;    // lookup result
      logic set_fail;      // zero result
      logic set_ok_only;   // ok = 1, rest 0
      logic rsp_load;      // move finished result to the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     intern_bad;   // null object or kind 0
      logic     scan_done;    // scan pointer reached high water
      logic     match;        // slot read matches object and kind
      logic     valid_handle; // slot read validates the handle
      logic     can_alloc;
   } sts_type;

endpackage

@@ design/ght_if.sv @@
interface ght_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/ght_ctrl.sv @@
module ght_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ght_pkg::sts_type sts,
   output ght_pkg::cmd_type cmd
);
   import ght_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_ALLOC_RD, S_ALLOC,
      S_HND_CHK, S_CLEAR, S_CLEAR_WR, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.func)
               FUNC_INTERN: begin
                  if (sts.intern_bad) begin
                     cmd.set_fail = 1'b1;
                     state_in = S_RESP;
                  end else state_in = S_SCAN_RD;
               end
               FUNC_LOOKUP, FUNC_RELEASE: begin
                  cmd.rd_slot = 1'b1;
                  cmd.use_handle = 1'b1;
                  state_in = S_HND_CHK;
               end
               FUNC_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  state_in = S_CLEAR;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SCAN_RD: begin
            if (sts.scan_done) begin
               cmd.rd_stack = 1'b1;
               state_in = S_ALLOC_RD;
            end else begin
               cmd.rd_slot = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (sts.match) begin
               cmd.set_hit = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         // fetch the generation of the slot popped from the stack
         S_ALLOC_RD: begin
            cmd.rd_slot = 1'b1;
            cmd.use_stack = 1'b1;
            state_in = S_ALLOC;
         end
         S_ALLOC: begin
            if (sts.can_alloc) cmd.intern_alloc = 1'b1;
            else cmd.set_fail = 1'b1;
            state_in = S_RESP;
         end
         S_HND_CHK: begin
            if (sts.func == FUNC_LOOKUP) cmd.set_lookup = 1'b1;
            else if (sts.valid_handle) cmd.do_release = 1'b1;
            else cmd.set_fail = 1'b1;
            state_in = S_RESP;
         end
         S_CLEAR: begin
            if (sts.scan_done) begin
               cmd.set_ok_only = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.rd_slot = 1'b1;
               state_in = S_CLEAR_WR;
            end
         end
         S_CLEAR_WR: begin
            cmd.clear_slot = 1'b1;
            cmd.scan_next = 1'b1;
            state_in = S_CLEAR;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.intern_alloc, cmd.do_release, cmd.clear_slot}) <= 1)
      else $error("conflicting slot writes");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DISPATCH)
      else $error("accept did not dispatch");
   a_resp_to_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == S_IDLE)
      else $error("result raised outside response");
`endif
endmodule

@@ design/ght_dpath.sv @@
module ght_dpath #(
   parameter int SLOTS    = 256,
   parameter int GEN_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  ght_pkg::req_type req,
   input  ght_pkg::cmd_type cmd,
   output ght_pkg::sts_type sts,
   output ght_pkg::rsp_type rsp
);
   import ght_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // memories; slots at or above high water are implicitly generation 1
   logic [63:0]       obj_mem  [SLOTS];
   logic [3:0]        kind_mem [SLOTS];
   logic [GEN_BITS-1:0] gen_mem [SLOTS];
   logic [IW-1:0]     stack_mem [SLOTS];
   logic [SLOTS-1:0]  used_ff;

   req_type           req_ff;
   logic [CW-1:0]     ptr_ff, free_cnt_ff, high_ff;
   logic [IW-1:0]     addr_ff;
   logic [63:0]       rd_obj_ff;
   logic [3:0]        rd_kind_ff;
   logic [GEN_BITS-1:0] rd_gen_ff;
   logic              rd_used_ff;
   logic [IW-1:0]     rd_stack_ff;
   rsp_type           rsp_ff, rsp_in, rsp_out_ff;

   logic [IW-1:0]     rd_addr, alloc_idx, wr_idx;
   logic [31:0]       h_low;
   logic [31:0]       h_gen;
   logic [32:0]       h_idx;
   logic              h_in_range, valid_h, from_stack;
   logic [GEN_BITS-1:0] gen_now, gen_next, alloc_gen;
   logic [63:0]       alloc_handle;

   assign h_low = req_ff.handle_in[31:0];
   assign h_gen = req_ff.handle_in[63:32];
   assign h_idx = {1'b0, h_low} - 33'd1;
   assign h_in_range = (h_low != 32'd0) && (h_idx < {{(33-CW){1'b0}}, high_ff});
   assign rd_addr = cmd.use_handle ? h_idx[IW-1:0] :
                    cmd.use_stack  ? rd_stack_ff : ptr_ff[IW-1:0];
   assign gen_now = rd_gen_ff;
   assign valid_h = h_in_range && rd_used_ff && (h_gen != 32'd0) &&
                    (32'(gen_now) == h_gen);
   assign from_stack = (free_cnt_ff != '0);
   assign alloc_idx = from_stack ? rd_stack_ff : high_ff[IW-1:0];
   assign alloc_gen = from_stack ? rd_gen_ff : GEN_BITS'(1);
   assign alloc_handle = 64'({alloc_gen, 32'(alloc_idx) + 32'd1});

   assign sts.func       = func_type'(req_ff.func);
   assign sts.intern_bad = (req_ff.object_id == 64'd0) || (req_ff.object_kind == 4'd0);
   assign sts.scan_done  = (ptr_ff == high_ff);
   assign sts.match      = rd_used_ff && (rd_kind_ff == req_ff.object_kind) &&
                           (rd_obj_ff == req_ff.object_id);
   assign sts.valid_handle = valid_h;
   assign sts.can_alloc  = from_stack || (high_ff != CW'(SLOTS));

   // slot being written and its next generation
   always_comb begin
      if (cmd.intern_alloc) wr_idx = alloc_idx;
      else if (cmd.do_release) wr_idx = addr_ff;
      else wr_idx = ptr_ff[IW-1:0];
      gen_next = gen_now + GEN_BITS'(1);
      if (gen_next == '0) gen_next = GEN_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_slot) begin
         rd_obj_ff  <= obj_mem[rd_addr];
         rd_kind_ff <= kind_mem[rd_addr];
         rd_gen_ff  <= gen_mem[rd_addr];
         rd_used_ff <= used_ff[rd_addr];
         addr_ff    <= rd_addr;
      end
      if (cmd.rd_stack) rd_stack_ff <= stack_mem[free_cnt_ff[IW-1:0] - IW'(1)];
      if (cmd.intern_alloc) begin
         obj_mem[wr_idx]  <= req_ff.object_id;
         kind_mem[wr_idx] <= req_ff.object_kind;
         // a slot taken at high water starts at generation 1
         if (!from_stack) gen_mem[wr_idx] <= GEN_BITS'(1);
      end
      if (cmd.do_release || cmd.clear_slot) begin
         kind_mem[wr_idx] <= 4'd0;
         gen_mem[wr_idx]  <= gen_next;
      end
      if (cmd.do_release) stack_mem[free_cnt_ff[IW-1:0]] <= wr_idx;
      if (cmd.clear_slot) stack_mem[ptr_ff[IW-1:0]] <= wr_idx;
      if (cmd.load_req) req_ff <= req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         ptr_ff      <= '0;
         free_cnt_ff <= '0;
         high_ff     <= '0;
      end else begin
         if (cmd.load_req) ptr_ff <= '0;
         else if (cmd.scan_next) ptr_ff <= ptr_ff + CW'(1);
         if (cmd.intern_alloc) begin
            used_ff[wr_idx] <= 1'b1;
            if (from_stack) free_cnt_ff <= free_cnt_ff - CW'(1);
            else high_ff <= high_ff + CW'(1);
         end
         if (cmd.do_release) begin
            used_ff[wr_idx] <= 1'b0;
            if (free_cnt_ff != CW'(SLOTS)) free_cnt_ff <= free_cnt_ff + CW'(1);
         end
         if (cmd.clear_start) free_cnt_ff <= '0;
         if (cmd.clear_slot) begin
            used_ff[wr_idx] <= 1'b0;
            free_cnt_ff     <= free_cnt_ff + CW'(1);
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.set_fail) rsp_in = '0;
      if (cmd.set_ok_only || cmd.do_release) begin
         rsp_in    = '0;
         rsp_in.ok = 1'b1;
      end
      if (cmd.set_hit) begin
         rsp_in = '0;
         rsp_in.handle_out = 64'({gen_now, 32'(addr_ff) + 32'd1});
         rsp_in.ok = 1'b1;
      end
      if (cmd.intern_alloc) begin
         rsp_in = '0;
         rsp_in.handle_out = alloc_handle;
         rsp_in.ok = 1'b1;
      end
      if (cmd.set_lookup) begin
         rsp_in = '0;
         if (valid_h) begin
            rsp_in.ok       = 1'b1;
            rsp_in.kind_out = rd_kind_ff;
            if (req_ff.object_kind == 4'd0 || req_ff.object_kind == rd_kind_ff)
               rsp_in.object_out = rd_obj_ff;
         end
      end
   end

   // output register holds the offered item while the next one is worked on
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.rsp_load) rsp_out_ff <= rsp_ff;
   end
   assign rsp = rsp_out_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= high_ff) else $error("free count above high water");
   a_high_bound: assert property (@(posedge clock) disable iff (reset)
      high_ff <= CW'(SLOTS)) else $error("high water overflow");
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.intern_alloc |-> sts.can_alloc) else $error("alloc on full table");
`endif
endmodule

@@ design/generational_handle_table.sv @@
// Lookup and release read the slot named by the handle; an intern with a null object
// or kind 0 is refused at once, else it scans the slots below high water for a match,
// then reuses a freed slot, takes the slot at high water or fails when full; clear
// frees each slot below high water in turn. One item at a time, the next accepted in
// the cycle the result is raised. A held result stalls the next item only at its end.
// Synchronous active-high reset empties the table at once (no sweep).
module generational_handle_table #(
   parameter int SLOTS    = 256,
   parameter int GEN_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   ght_if.sink   req,
   ght_if.source rsp
);
   import ght_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   ght_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );

   ght_dpath #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_dpath (
      .clock, .reset,
      .req(req_type'(req.data)),
      .cmd, .sts, .rsp(rsp_data)
   );

   assign rsp.data = rsp_data;
endmodule
